### rtl/fsog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsog_pkg
// Shared types, constants and elaboration-time tables of the fingered sine
// oscillator: note increments, quarter-wave sine table, codes and states.
// ----------------------------------------------------------------------------
package fsog_pkg;

   // Sizes of the block
   localparam int BLOCK_SAMPLES = 512;
   localparam int SINE_DEPTH    = 1024;
   localparam int SAMPLE_RATE   = 44100;

   localparam int BLOCK_BITS   = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam int SINE_BITS    = $clog2(SINE_DEPTH);
   localparam int SINE_QUARTER = SINE_DEPTH / 4;
   localparam int ROM_ADDR_W   = SINE_BITS - 1;
   localparam int SINE_VAL_W   = 15;

   // Port widths
   localparam int REQ_DATA_W = 8;   // button[2:0], pressed[3], zero fill
   localparam int RSP_DATA_W = 40;  // left[15:0], right[31:16], note[34:32], zero fill
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // Request kinds
   localparam logic FUNC_BUTTON = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE  = 2'd2;

   localparam logic [15:0] VOLUME_RESET = 16'd6554;
   localparam logic [16:0] PAN_RESET    = 17'd32768;
   localparam logic [16:0] PAN_FULL     = 17'd65536;

   // Buttons and fingerings
   localparam int          BUTTON_COUNT = 5;
   localparam logic [2:0]  BUTTON_LIMIT = 3'(BUTTON_COUNT);
   localparam logic [4:0]  FINGER_NOTE0 = 5'h1F;
   localparam logic [4:0]  FINGER_NOTE1 = 5'h0F;
   localparam logic [4:0]  FINGER_NOTE2 = 5'h07;
   localparam logic [4:0]  FINGER_NOTE3 = 5'h03;
   localparam logic [4:0]  FINGER_NOTE4 = 5'h01;
   localparam logic [4:0]  FINGER_NOTE5 = 5'h00;
   localparam logic [2:0]  NOTE0 = 3'd0;
   localparam logic [2:0]  NOTE1 = 3'd1;
   localparam logic [2:0]  NOTE2 = 3'd2;
   localparam logic [2:0]  NOTE3 = 3'd3;
   localparam logic [2:0]  NOTE4 = 3'd4;
   localparam logic [2:0]  NOTE5 = 3'd5;
   localparam int          NOTE_COUNT = 6;

   // Noise generator
   localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
   localparam logic [31:0] LFSR_RESET = 32'd1;

   // Glide divide by ten: 32-bit reciprocal, quotient is (n * RECIP) >> SHIFT
   localparam logic [31:0] GLIDE_RECIP = 32'hCCCC_CCCD;
   localparam int          GLIDE_SHIFT = 35;

   // Shared multiplier operands
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Note frequencies in hundredths of a hertz
   localparam logic [15:0] NOTE_CENTIHZ [NOTE_COUNT] =
      '{16'd29366, 16'd32963, 16'd36999, 16'd44000, 16'd49388, 16'd58733};

   typedef logic [31:0] step_table_type [8];
   typedef logic [SINE_VAL_W-1:0] sine_rom_type [SINE_QUARTER+1];

   // Phase increment of each note, rounded; codes six and seven alias note five
   function automatic step_table_type build_step_table();
      step_table_type tbl;
      logic [63:0] f;
      for (int n = 0; n < 8; n++) begin
         f = 64'(NOTE_CENTIHZ[(n < NOTE_COUNT) ? n : NOTE_COUNT - 1]);
         tbl[n] = 32'(((f << 32) + 64'(50 * SAMPLE_RATE)) / 64'(100 * SAMPLE_RATE));
      end
      return tbl;
   endfunction

   localparam step_table_type NOTE_STEP = build_step_table();

   // Quarter-wave sine magnitude, Q30 Taylor series to degree nine
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] rem;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      for (int a = 0; a <= SINE_QUARTER; a++) begin
         rem = 64'(a) * 64'd4;
         x   = (Q30_HALF_PI * rem) / 64'(SINE_DEPTH);
         x2  = (x * x) >> 30;
         t   = Q30_ONE - x2 / 64'd72;
         t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s   = (x * t) >> 30;
         v   = (s * 64'd32767 + 64'd536870912) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[a] = SINE_VAL_W'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Live configuration seen by the back end
   typedef struct packed {
      logic [15:0] volume;
      logic [16:0] pan;
      logic        noise_enable;
   } cfg_type;

   // Tick queue handshake between front and back
   typedef struct packed {
      logic       push;
      logic [2:0] note;
   } queue_wr_type;

   typedef struct packed {
      logic       empty;
      logic [2:0] note;
   } queue_rd_type;

   // Back end sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GLIDE_DIFF,
      ST_GLIDE_MUL,
      ST_GLIDE_ADD,
      ST_PHASE,
      ST_ROM_ADDR,
      ST_ROM_DATA,
      ST_MUL_LA,
      ST_MUL_LB,
      ST_MUL_RA,
      ST_MUL_RB,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic mul_prod;   // second multiply: product times share
      logic mul_right;  // right channel operands
      logic load_out;
   } back_ctrl_type;

endpackage

### rtl/fsog_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsog_front
// Accepts requests, tracks held buttons and the fingered note, and queues
// each sample tick with the note that is current when it arrives.
// ----------------------------------------------------------------------------
module fsog_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tuser,   // func
   input  logic [fsog_pkg::REQ_DATA_W-1:0] req_tdata,  // button[2:0], pressed[3]
   input  logic                           queue_full,
   output fsog_pkg::queue_wr_type         queue_wr
);
   import fsog_pkg::*;

   logic [4:0] flags_ff, flags_in;
   logic [2:0] note_ff, note_in;
   logic       accept;
   logic [2:0] button;
   logic       pressed;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign button     = req_tdata[2:0];
   assign pressed    = req_tdata[3];

   // Update held flags and re-decode the fingering
   always_comb begin
      flags_in = flags_ff;
      if (button < BUTTON_LIMIT) begin
         flags_in[button] = pressed;
      end
      note_in = note_ff;
      unique case (flags_in)
         FINGER_NOTE0: note_in = NOTE0;
         FINGER_NOTE1: note_in = NOTE1;
         FINGER_NOTE2: note_in = NOTE2;
         FINGER_NOTE3: note_in = NOTE3;
         FINGER_NOTE4: note_in = NOTE4;
         FINGER_NOTE5: note_in = NOTE5;
         default:      note_in = note_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         note_ff  <= NOTE5;
      end else if (accept && req_tuser == FUNC_BUTTON) begin
         flags_ff <= flags_in;
         note_ff  <= note_in;
      end
   end

   // Queue ticks only; button events end here
   assign queue_wr.push = accept && req_tuser == FUNC_TICK;
   assign queue_wr.note = note_ff;

endmodule

### rtl/fsog_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsog_queue
// Two-entry queue of pending ticks between the front and the back end.
// ----------------------------------------------------------------------------
module fsog_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  fsog_pkg::queue_wr_type queue_wr,
   input  logic                   pop,
   output logic                   full,
   output fsog_pkg::queue_rd_type queue_rd
);
   import fsog_pkg::*;

   logic [2:0] slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full           = count_ff == 2'd2;
   assign queue_rd.empty = count_ff == 2'd0;
   assign queue_rd.note  = slot_ff[rd_ptr_ff];

   // Store payload
   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.note;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (queue_wr.push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({queue_wr.push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### rtl/fsog_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsog_back
// Runs one tick at a time: glide at block start, phase advance and sine lookup,
// or only a noise step in noise mode; then volume and pan share one multiplier.
// ----------------------------------------------------------------------------
module fsog_back (
   input  logic                            clock,
   input  logic                            reset,
   input  fsog_pkg::cfg_type               cfg,
   input  fsog_pkg::queue_rd_type          queue_rd,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fsog_pkg::RSP_DATA_W-1:0] rsp_tdata   // left[15:0], right[31:16],
                                                       // note[34:32]
);
   import fsog_pkg::*;

   back_state_type state_ff, state_in;
   back_ctrl_type  ctrl;

   logic [31:0]            phase_step_ff;
   logic [31:0]            phase_acc_ff;
   logic [BLOCK_BITS-1:0]  block_pos_ff;
   logic [31:0]            lfsr_ff;
   logic [2:0]             note_ff;
   logic                   glide_neg_ff;
   logic [31:0]            glide_mag_ff;
   logic [31:0]            glide_quo_ff;
   logic [SINE_VAL_W-1:0]  rom_ff;
   logic                   neg_ff;
   logic signed [15:0]     src_l_ff;
   logic signed [15:0]     src_r_ff;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic [15:0]            left_ff;
   logic                   out_valid_ff;
   logic [15:0]            out_left_ff;
   logic [15:0]            out_right_ff;
   logic [2:0]             out_note_ff;

   logic [31:0]            lfsr_in;
   logic [31:0]            target;
   logic [32:0]            glide_diff;
   logic [63:0]            glide_prod;
   logic [31:0]            glide_next;
   logic [1:0]             quad;
   logic [ROM_ADDR_W-1:0]  rom_addr;
   logic [16:0]            right_share;
   logic [16:0]            left_share;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [15:0]            mix_out;
   logic                   out_free;
   logic                   block_start;

   assign target      = NOTE_STEP[note_ff];
   assign out_free    = !out_valid_ff || rsp_tready;
   assign block_start = block_pos_ff == '0;

   // Galois step of the noise register
   always_comb begin
      lfsr_in = lfsr_ff >> 1;
      if (lfsr_ff[0]) begin
         lfsr_in = lfsr_in ^ LFSR_MASK;
      end
   end

   // Glide as target plus the difference over ten, rounded down; a negative
   // difference divides its complement and takes one more off
   assign glide_diff = {1'b0, phase_step_ff} - {1'b0, target};
   assign glide_prod = 64'(glide_mag_ff) * 64'(GLIDE_RECIP);
   assign glide_next = glide_neg_ff ? target - glide_quo_ff - 32'd1
                                    : target + glide_quo_ff;

   // Quarter-wave address from the top phase bits
   assign quad     = phase_acc_ff[31:30];
   assign rom_addr = quad[0]
      ? ROM_ADDR_W'(SINE_QUARTER) - {1'b0, phase_acc_ff[29 -: (SINE_BITS - 2)]}
      : {1'b0, phase_acc_ff[29 -: (SINE_BITS - 2)]};

   // Pan shares, saturated above one
   assign right_share = (cfg.pan > PAN_FULL) ? PAN_FULL : cfg.pan;
   assign left_share  = PAN_FULL - right_share;

   // Shared multiplier operands
   always_comb begin
      if (ctrl.mul_prod) begin
         mul_a = MUL_A_W'(signed'(prod_ff[31:0]));
         mul_b = MUL_B_W'(signed'({1'b0, ctrl.mul_right ? right_share : left_share}));
      end else begin
         mul_a = MUL_A_W'(ctrl.mul_right ? src_r_ff : src_l_ff);
         mul_b = MUL_B_W'(signed'({2'b00, cfg.volume}));
      end
   end

   // Divide product by 2^32 toward zero, keep low sixteen bits
   assign mix_out = prod_ff[47:32]
      + 16'(prod_ff[MUL_P_W-1] && (prod_ff[31:0] != '0));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_rd.empty) begin
               if (cfg.noise_enable) begin
                  state_in = ST_MUL_LA;
               end else if (block_start) begin
                  state_in = ST_GLIDE_DIFF;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end
         ST_GLIDE_DIFF: state_in = ST_GLIDE_MUL;
         ST_GLIDE_MUL:  state_in = ST_GLIDE_ADD;
         ST_GLIDE_ADD:  state_in = ST_PHASE;
         ST_PHASE:      state_in = ST_ROM_ADDR;
         ST_ROM_ADDR:   state_in = ST_ROM_DATA;
         ST_ROM_DATA:   state_in = ST_MUL_LA;
         ST_MUL_LA:     state_in = ST_MUL_LB;
         ST_MUL_LB:     state_in = ST_MUL_RA;
         ST_MUL_RA:     state_in = ST_MUL_RB;
         ST_MUL_RB:     state_in = ST_DONE;
         ST_DONE:       state_in = out_free ? ST_IDLE : ST_DONE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:   ctrl.pop = !queue_rd.empty;
         ST_MUL_LB: ctrl.mul_prod = 1'b1;
         ST_MUL_RA: ctrl.mul_right = 1'b1;
         ST_MUL_RB: begin
            ctrl.mul_prod  = 1'b1;
            ctrl.mul_right = 1'b1;
         end
         ST_DONE:   ctrl.load_out = out_free;
         default:   ctrl = '0;
      endcase
   end

   assign pop = ctrl.pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         phase_acc_ff  <= '0;
         block_pos_ff  <= '0;
         lfsr_ff       <= LFSR_RESET;
      end else begin
         if (ctrl.pop) begin
            if (block_pos_ff == BLOCK_BITS'(BLOCK_SAMPLES - 1)) begin
               block_pos_ff <= '0;
            end else begin
               block_pos_ff <= block_pos_ff + 1'b1;
            end
            if (cfg.noise_enable) begin
               lfsr_ff <= lfsr_in;
            end
         end
         if (state_ff == ST_GLIDE_ADD) begin
            phase_step_ff <= glide_next;
         end
         if (state_ff == ST_PHASE) begin
            phase_acc_ff <= phase_acc_ff + phase_step_ff;
         end
      end
   end

   // Datapath working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            note_ff  <= queue_rd.note;
            src_l_ff <= 16'({1'b0, lfsr_in[14:0]});
            src_r_ff <= 16'({1'b0, lfsr_in[30:16]});
         end
         ST_GLIDE_DIFF: begin
            glide_neg_ff <= glide_diff[32];
            glide_mag_ff <= glide_diff[32] ? ~glide_diff[31:0] : glide_diff[31:0];
         end
         ST_GLIDE_MUL: begin
            glide_quo_ff <= 32'(glide_prod >> GLIDE_SHIFT);
         end
         ST_ROM_ADDR: begin
            rom_ff <= SINE_ROM[rom_addr];
            neg_ff <= quad[1];
         end
         ST_ROM_DATA: begin
            src_l_ff <= neg_ff ? -16'({1'b0, rom_ff}) : 16'({1'b0, rom_ff});
            src_r_ff <= neg_ff ? -16'({1'b0, rom_ff}) : 16'({1'b0, rom_ff});
         end
         ST_MUL_LA, ST_MUL_LB, ST_MUL_RB: begin
            prod_ff <= mul_a * mul_b;
         end
         ST_MUL_RA: begin
            left_ff <= mix_out;
            prod_ff <= mul_a * mul_b;
         end
         default: begin
            rom_ff <= rom_ff;
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         out_left_ff  <= left_ff;
         out_right_ff <= mix_out;
         out_note_ff  <= note_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_note_ff, out_right_ff, out_left_ff};

endmodule

### rtl/fingered_sine_oscillator_with_glide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingered_sine_oscillator_with_glide
// Flute-fingered oscillator: button events pick a note, sample ticks give a
// panned sine or noise sample; sine ticks glide the step at each block start.
// ----------------------------------------------------------------------------
// A sine tick passes through phase advance and sine lookup, then the left and
//   right volume and pan multiplies; the first tick of a block first takes a
//   three-step glide with a reciprocal divide; noise ticks go straight to them.
// The back-end sequencer takes one tick at a time, with one shared multiplier
//   for volume and pan, and pops the next only after the last result is loaded.
// The front stalls all requests while two ticks are queued.
// Reset (synchronous): note five, step and phase zero, noise register one.
// ----------------------------------------------------------------------------
module fingered_sine_oscillator_with_glide (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,  // func
   input  logic [fsog_pkg::REQ_DATA_W-1:0]  req_tdata,  // button[2:0], pressed[3]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fsog_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // left[15:0], right[31:16],
                                                        // note_index[34:32]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fsog_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsog_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fsog_pkg::*;

   logic [15:0]  volume_ff;
   logic [16:0]  pan_ff;
   logic         noise_ff;
   cfg_type      cfg;
   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         pop;

   assign csr_ready = 1'b1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
         pan_ff    <= PAN_RESET;
         noise_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VOLUME: volume_ff <= csr_data[15:0];
            CSR_PAN:    pan_ff    <= csr_data;
            CSR_NOISE:  noise_ff  <= csr_data[0];
            default:    volume_ff <= volume_ff;
         endcase
      end
   end

   assign cfg.volume       = volume_ff;
   assign cfg.pan          = pan_ff;
   assign cfg.noise_enable = noise_ff;

   fsog_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   fsog_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .full     (queue_full),
      .queue_rd (queue_rd)
   );

   fsog_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .queue_rd   (queue_rd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/fsog_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsog_checker
// Port-level checks of the oscillator's result channel and reset.
// ----------------------------------------------------------------------------
module fsog_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fsog_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fsog_pkg::*;

   // Keep a stalled result offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Keep a stalled result unchanged
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // Report only fingered notes, with the fill bits clear
   a_note_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:32] <= NOTE5) && (rsp_tdata[39:35] == '0))
      else $error("result note out of range");

endmodule

bind fingered_sine_oscillator_with_glide fsog_checker u_fsog_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
